// File: rtl/core/pve_pkg.sv
// Shared types and constants for the population variance engine.
// No dependencies; imported by pve_calc and population_variance_engine.
package pve_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 26;
    localparam int SQSUM_W      = 41;
    localparam int CNT_W        = 11;
    localparam int VAR_W        = 38;
    localparam int PROD_W       = 52;
    localparam int DEN_W        = 22;
    localparam int DIFF_W       = 50;
    localparam int FRAC_W       = 8;
    localparam int NUM_W        = DIFF_W + FRAC_W;
    localparam int REM_W        = DEN_W;
    localparam int ALU_W        = NUM_W;
    localparam int STEP_W       = 6;
    localparam int OUT_TDATA_W  = 56;

    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_PRD  = 7'b0000100,
        S_DEN  = 7'b0001000,
        S_SUB  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_calc_state;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   sum_mag;
        logic [SQSUM_W-1:0] sqsum;
        logic [CNT_W-1:0]   count;
        logic               overflow;
    } t_calc_req;

    typedef struct packed {
        logic               done;
        logic [VAR_W-1:0]   variance;
        logic [CNT_W-1:0]   count;
        logic               overflow;
    } t_calc_res;

endpackage

// File: rtl/core/pve_calc.sv
// Column-end arithmetic: shift-add products and restoring division on one
// shared adder. Depends on pve_pkg.
module pve_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pve_pkg::t_calc_req i_req,
    input  logic               i_ack,
    output logic               o_busy,
    output pve_pkg::t_calc_res o_res
);
    import pve_pkg::*;

    localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] N_LAST   = STEP_W'(CNT_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);

    t_calc_state        r_state;
    logic [STEP_W-1:0]  r_step;
    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_mc;
    logic [SUM_W-1:0]   r_ml;
    logic [PROD_W-1:0]  r_sq;
    logic [PROD_W-1:0]  r_prod;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;
    logic [REM_W-1:0]   r_rem;
    logic [SQSUM_W-1:0] r_s2;
    logic [CNT_W-1:0]   r_n;
    logic               r_ovf;

    logic [ALU_W-1:0]   w_a;
    logic [ALU_W-1:0]   w_b;
    logic               w_sub;
    logic [ALU_W:0]     w_sum;
    logic [REM_W:0]     w_t;
    logic               w_q;

    always_comb begin
        w_t   = {r_rem, r_num[NUM_W-1]};
        w_a   = {{(ALU_W-PROD_W){1'b0}}, r_acc};
        w_b   = r_ml[0] ? {{(ALU_W-PROD_W){1'b0}}, r_mc} : '0;
        w_sub = 1'b0;
        unique case (r_state)
            S_SUB: begin
                w_a   = {{(ALU_W-PROD_W){1'b0}}, r_prod};
                w_b   = {{(ALU_W-PROD_W){1'b0}}, r_sq};
                w_sub = 1'b1;
            end
            S_DIV: begin
                w_a   = {{(ALU_W-REM_W-1){1'b0}}, w_t};
                w_b   = {{(ALU_W-DEN_W){1'b0}}, r_den};
                w_sub = 1'b1;
            end
            default: begin
            end
        endcase
        w_sum = {1'b0, w_a} + {1'b0, (w_sub ? ~w_b : w_b)} + {{ALU_W{1'b0}}, w_sub};
        w_q   = w_sum[ALU_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_state <= S_SQ;
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_mc    <= {{(PROD_W-SUM_W){1'b0}}, i_req.sum_mag};
                        r_ml    <= i_req.sum_mag;
                        r_s2    <= i_req.sqsum;
                        r_n     <= i_req.count;
                        r_ovf   <= i_req.overflow;
                    end
                end
                S_SQ: begin
                    r_acc  <= w_sum[PROD_W-1:0];
                    r_mc   <= {r_mc[PROD_W-2:0], 1'b0};
                    r_ml   <= {1'b0, r_ml[SUM_W-1:1]};
                    r_step <= r_step + 1'b1;
                    if (r_step == SQ_LAST) begin
                        r_sq    <= w_sum[PROD_W-1:0];
                        r_acc   <= '0;
                        r_mc    <= {{(PROD_W-SQSUM_W){1'b0}}, r_s2};
                        r_ml    <= {{(SUM_W-CNT_W){1'b0}}, r_n};
                        r_step  <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_acc  <= w_sum[PROD_W-1:0];
                    r_mc   <= {r_mc[PROD_W-2:0], 1'b0};
                    r_ml   <= {1'b0, r_ml[SUM_W-1:1]};
                    r_step <= r_step + 1'b1;
                    if (r_step == N_LAST) begin
                        r_prod  <= w_sum[PROD_W-1:0];
                        r_acc   <= '0;
                        r_mc    <= {{(PROD_W-CNT_W){1'b0}}, r_n};
                        r_ml    <= {{(SUM_W-CNT_W){1'b0}}, r_n};
                        r_step  <= '0;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_acc  <= w_sum[PROD_W-1:0];
                    r_mc   <= {r_mc[PROD_W-2:0], 1'b0};
                    r_ml   <= {1'b0, r_ml[SUM_W-1:1]};
                    r_step <= r_step + 1'b1;
                    if (r_step == N_LAST) begin
                        r_den   <= w_sum[DEN_W-1:0];
                        r_step  <= '0;
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    r_num   <= w_q ? {w_sum[DIFF_W-1:0], {FRAC_W{1'b0}}} : '0;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num  <= {r_num[NUM_W-2:0], w_q};
                    r_rem  <= w_q ? w_sum[REM_W-1:0] : w_t[REM_W-1:0];
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_res.done     = (r_state == S_DONE);
    assign o_res.variance = r_num[VAR_W-1:0];
    assign o_res.count    = r_n;
    assign o_res.overflow = r_ovf;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("calc started while busy");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_den != '0)
        else $error("zero divisor");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den)
        else $error("remainder not below divisor");
    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ack |-> r_state == S_DONE)
        else $error("result taken before done");

endmodule

// File: rtl/core/population_variance_engine.sv
// Top level of the population variance engine: sample accumulation, the
// result register and the stream ports. Depends on pve_pkg and pve_calc.
//
// Input stream: s_axis tdata carries one signed sample, tlast closes the column.
// While the adder sequencer is idle, a column streams at one sample per
// cycle. The request with tlast set ends the column and starts the shared
// adder sequencer: sum^2, then n*sumsq, then n^2, then the difference and
// then the restoring division, after which the result is handed over, so
// s_axis_tready stays low from the accepted tlast sample until the sequencer
// has handed its result over and is idle again.
// The result (variance with 8 fractional bits, sample count, overflow flag)
// then moves to the output register and m_axis_tvalid rises; the next
// column may already stream in while that request waits. If the receiver
// stalls and a second column ends, that result waits in the sequencer and
// input stays blocked until the output register frees.
// Samples beyond MAX_SAMPLES in one column are dropped and set the overflow
// flag. Reset is synchronous and clears the accumulators, the sequencer and
// the output valid.
module population_variance_engine #(
    parameter int MAX_SAMPLES = pve_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = pve_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pve_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // [15:0] sample
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [37:0] variance, [48:38] sample_count, [49] overflow, [55:50] zero
    output logic [pve_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import pve_pkg::*;

    localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic signed [SUM_W-1:0] r_sum;
    logic [SQSUM_W-1:0]      r_sqsum;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_ovf;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    logic signed [SUM_W-1:0] n_sum;
    logic [SQSUM_W-1:0]      n_sqsum;
    logic [CNT_W-1:0]        n_cnt;
    logic                    n_ovf;

    logic [SAMPLE_W-1:0]          w_shl;
    logic signed [SAMPLE_W-1:0]   w_s;
    logic signed [2*SAMPLE_W-1:0] w_sq;
    logic                         w_in_acc;
    logic                         w_busy;
    logic                         w_ack;
    t_calc_req                    w_req;
    t_calc_res                    w_res;

    always_comb begin
        w_shl   = s_axis_tdata << SHIFT;
        w_s     = $signed(w_shl) >>> SHIFT;
        w_sq    = w_s * w_s;
        n_sum   = r_sum;
        n_sqsum = r_sqsum;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        if (r_cnt >= MAX_CNT) begin
            n_ovf = 1'b1;
        end else begin
            n_sum   = r_sum + {{(SUM_W-SAMPLE_W){w_s[SAMPLE_W-1]}}, w_s};
            n_sqsum = r_sqsum + {{(SQSUM_W-2*SAMPLE_W+1){1'b0}}, w_sq[2*SAMPLE_W-2:0]};
            n_cnt   = r_cnt + 1'b1;
        end
    end

    assign s_axis_tready = !w_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_req.start    = w_in_acc && s_axis_tlast;
        w_req.sum_mag  = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
        w_req.sqsum    = n_sqsum;
        w_req.count    = n_cnt;
        w_req.overflow = n_ovf;
    end

    assign w_ack = w_res.done && (!r_out_valid || m_axis_tready);

    pve_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_ack   (w_ack),
        .o_busy  (w_busy),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                if (s_axis_tlast) begin
                    r_sum   <= '0;
                    r_sqsum <= '0;
                    r_cnt   <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_sum   <= n_sum;
                    r_sqsum <= n_sqsum;
                    r_cnt   <= n_cnt;
                    r_ovf   <= n_ovf;
                end
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out_data <= {{(OUT_TDATA_W-VAR_W-CNT_W-1){1'b0}},
                           w_res.overflow, w_res.count, w_res.variance};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("count above limit");
    a_ovf_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_cnt == MAX_CNT)
        else $error("overflow flag without saturated count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ack && r_out_valid |-> m_axis_tready)
        else $error("pending result overwritten");

endmodule

// File: bench/population_variance_engine_tb.sv
// Self-checking bench for population_variance_engine: drives sample columns on the input
// stream and checks every variance result against a bit-true predictor or a pinned value.
// Depends on pve_pkg and the population_variance_engine RTL.
module population_variance_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pve_pkg::*;

    localparam int MAX_COUNT = DEF_MAX_SAMPLES;
    localparam int N_ROWS    = 13;

    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_column_result;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                lst;
        int                  reps;
        logic                pinned;
        t_column_result      res;
    } t_stim_row;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata = '0;   // [15:0] sample
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [37:0] variance, [48:38] sample_count, [49] overflow, [55:50] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic signed [SUM_W-1:0] col_sum = '0;
    logic [SQSUM_W-1:0]      col_sqsum = '0;
    logic [CNT_W-1:0]        col_count = '0;
    logic                    col_ovf = 1'b0;

    t_column_result variances_due[$];
    int             mismatches = 0;
    int             burst_left = 0;
    t_rx_mode       rx_mode = RX_ALWAYS;
    int             rx_tick = 0;

    t_stim_row directed_rows [0:N_ROWS-1] = '{
        '{16'h0000, 1'b1, 1,    1'b1, '{38'd0,   11'd1,    1'b0}},
        '{16'h7fff, 1'b1, 1,    1'b1, '{38'd0,   11'd1,    1'b0}},
        '{16'h8000, 1'b1, 1,    1'b1, '{38'd0,   11'd1,    1'b0}},
        '{16'h0001, 1'b0, 1,    1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'hffff, 1'b1, 1,    1'b1, '{38'd256, 11'd2,    1'b0}},
        '{16'h7fff, 1'b0, 512,  1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'h8000, 1'b1, 515,  1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'h0003, 1'b0, 1,    1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'h0005, 1'b0, 1,    1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'hfff9, 1'b1, 1,    1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'h8000, 1'b0, 1,    1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'h7fff, 1'b0, 1,    1'b0, '{38'd0,   11'd0,    1'b0}},
        '{16'h0000, 1'b1, 1,    1'b0, '{38'd0,   11'd0,    1'b0}}
    };

    population_variance_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] raw, input logic lst,
                                             output t_column_result res);
        logic signed [SAMPLE_W-1:0] s;
        longint                     sv;
        longint                     total;
        longint unsigned            mag;
        longint unsigned            n;
        longint unsigned            prod;
        longint unsigned            sq;
        longint unsigned            diff;
        s = raw;
        sv = s;
        res = '0;
        if (col_count >= CNT_W'(MAX_COUNT)) begin
            col_ovf = 1'b1;
        end else begin
            col_sum = col_sum + SUM_W'(sv);
            col_sqsum = col_sqsum + SQSUM_W'(sv * sv);
            col_count = col_count + 1'b1;
        end
        if (!lst) begin
            return 1'b0;
        end
        total = col_sum;
        mag = (total < 0) ? -total : total;
        n = col_count;
        sq = mag * mag;
        prod = n * col_sqsum;
        diff = (prod >= sq) ? prod - sq : 0;
        res.variance = (n == 0) ? '0 : VAR_W'((diff << FRAC_W) / (n * n));
        res.count = col_count;
        res.overflow = col_ovf;
        col_sum = '0;
        col_sqsum = '0;
        col_count = '0;
        col_ovf = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                               input logic pinned, input t_column_result pinned_res);
        int             gap;
        t_column_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (accumulate_sample(smp, lst, res)) begin
            if (pinned) begin
                res = pinned_res;
            end
            variances_due.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
        end
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_column_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (variances_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result with none pending: %h", m_axis_tdata);
                end
            end else begin
                want = variances_due.pop_front();
                if (m_axis_tdata[VAR_W-1:0] !== want.variance) begin
                    report_mismatch("variance", want.variance, m_axis_tdata[VAR_W-1:0]);
                end
                if (m_axis_tdata[VAR_W +: CNT_W] !== want.count) begin
                    report_mismatch("sample_count", want.count, m_axis_tdata[VAR_W +: CNT_W]);
                end
                if (m_axis_tdata[VAR_W+CNT_W] !== want.overflow) begin
                    report_mismatch("overflow", want.overflow, m_axis_tdata[VAR_W+CNT_W]);
                end
                if (m_axis_tdata[OUT_TDATA_W-1:VAR_W+CNT_W+1] !== '0) begin
                    report_mismatch("padding", 0, m_axis_tdata[OUT_TDATA_W-1:VAR_W+CNT_W+1]);
                end
            end
        end
    end

    initial begin
        int          random_sent;
        int          len;
        int          pick;
        logic [15:0] smp;
        random_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_sample(directed_rows[r].smp,
                            directed_rows[r].lst && (k == directed_rows[r].reps - 1),
                            directed_rows[r].pinned, directed_rows[r].res);
            end
        end
        while (random_sent < 1000) begin
            pick = $urandom_range(0, 99);
            if (pick == 0) begin
                len = $urandom_range(MAX_COUNT - 4, MAX_COUNT + 6);
            end else if (pick < 20) begin
                len = $urandom_range(17, 80);
            end else begin
                len = $urandom_range(1, 16);
            end
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 7))
                    0:       smp = 16'h7fff;
                    1:       smp = 16'h8000;
                    2:       smp = 16'h0000;
                    3:       smp = 16'hffff;
                    default: smp = 16'($urandom);
                endcase
                send_sample(smp, k == len - 1, 1'b0, '0);
            end
            random_sent += len;
        end
        s_axis_tvalid <= 1'b0;
        while (variances_due.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (mismatches == 0 && variances_due.size() == 0) begin
            $display("population_variance_engine_tb OK");
        end else begin
            $display("population_variance_engine_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("population_variance_engine_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pve_pkg.sv
rtl/core/pve_calc.sv
rtl/core/population_variance_engine.sv
bench/population_variance_engine_tb.sv
